>>> sv/ltr_pkg.sv
// Shared constants for the local time-step rate unit.
`default_nettype none

package ltr_pkg;

    // Store geometry
    localparam int CELLS       = 65536;
    localparam int STORE_DEPTH = (CELLS < 65536) ? CELLS : 65536;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Field widths
    localparam int CELL_W      = 16;
    localparam int SUM_W       = 48;
    localparam int FIX_W       = 32;
    localparam int ACT_W       = 2;
    localparam int PROD_W      = 2 * FIX_W;
    localparam int IN_DATA_W   = 2 * CELL_W + 3 * FIX_W;
    localparam int OUT_DATA_W  = CELL_W + FIX_W;
    localparam int OUT_USER_W  = 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = FIX_W;
    localparam int CNT_W       = $clog2(FIX_W);

    // Cells at or above this limit read as zero and are never written
    localparam logic [CELL_W:0] CELL_LIMIT = (CELL_W + 1)'(STORE_DEPTH);

    // Item kinds
    localparam logic [ACT_W-1:0] ACT_INTERNAL = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BOUNDARY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH   = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RELAX_GAIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RATE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MASS_MODE  = 2'd2;

    // Register reset values
    localparam logic [FIX_W-1:0] RELAX_GAIN_RESET = 32'hFFFF_0000;
    localparam logic [FIX_W-1:0] MIN_RATE_RESET   = 32'h0001_0000;

    // Limits
    localparam logic [FIX_W-1:0]  RATE_MAX  = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
    localparam logic [PROD_W-1:0] CLAMP_MAG = 64'h4000_0000_0000_0000;

endpackage

`default_nettype wire

>>> sv/ltr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ltr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wen,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/local_timestep_rate_unit.sv
// Top level of the local time-step rate unit: face accumulation and cell finish.
`default_nettype none

// Accumulates face flux magnitudes into per-cell outflow and inflow stores and,
// on a finish item, reports (inflow + relax_gain*outflow) / divisor in unsigned
// Q16.16, floored at min_rate and clipped to all ones. After reset the unit
// zeroes every address of both stores with s_tready low; configuration
// writes are taken during that pass. For a face item the accept cycle issues
// the store reads and the next cycle writes the saturated sums back. A finish
// item runs three passes through one shared 32x32 multiplier, a numerator add,
// a divisor load, then 32 restoring division steps on one 66-bit subtractor
// (skipped when the numerator is not positive or the quotient overflows), and
// a final step that loads the output register and clears the cell. It waits in
// that step while an earlier result is still held on m_tdata.
module local_timestep_rate_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write port
    input  wire logic                               cfg_wen,
    input  wire logic [ltr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ltr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input items
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // owner_cell, neighbour_cell, face_flux, cell_volume, cell_density
    input  wire logic [ltr_pkg::IN_DATA_W-1:0]      s_tdata,
    // action
    input  wire logic [ltr_pkg::ACT_W-1:0]          s_tuser,
    // result items
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // cell_index, local_rate
    output logic      [ltr_pkg::OUT_DATA_W-1:0]     m_tdata,
    // saturated
    output logic      [ltr_pkg::OUT_USER_W-1:0]     m_tuser
);

    localparam int AW = ltr_pkg::ADDR_W;
    localparam int CW = ltr_pkg::CELL_W;
    localparam int SW = ltr_pkg::SUM_W;
    localparam int FW = ltr_pkg::FIX_W;
    localparam int PW = ltr_pkg::PROD_W;

    localparam logic [AW-1:0] LAST_ADDR = AW'(ltr_pkg::STORE_DEPTH - 1);
    localparam logic [ltr_pkg::CNT_W-1:0] LAST_STEP = ltr_pkg::CNT_W'(FW - 1);

    // Sequencer states
    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_ACCUM  = 4'd2;
    localparam logic [3:0] ST_MUL_HI = 4'd3;
    localparam logic [3:0] ST_MUL_LO = 4'd4;
    localparam logic [3:0] ST_SUM    = 4'd5;
    localparam logic [3:0] ST_NUM    = 4'd6;
    localparam logic [3:0] ST_LOAD   = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    // Control registers
    logic [3:0]                 state_reg, state_next;
    logic [AW-1:0]              clr_reg, clr_next;
    logic [ltr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic [FW-1:0]              relax_gain_reg, relax_gain_next;
    logic [FW-1:0]              min_rate_reg, min_rate_next;
    logic                       mass_mode_reg, mass_mode_next;

    // Payload registers
    logic                       we_out_reg, we_out_next;
    logic                       we_in_reg, we_in_next;
    logic [AW-1:0]              out_addr_reg, out_addr_next;
    logic [AW-1:0]              in_addr_reg, in_addr_next;
    logic [FW-1:0]              mag_reg, mag_next;
    logic [CW-1:0]              own_reg, own_next;
    logic                       own_ok_reg, own_ok_next;
    logic [FW-1:0]              vol_reg, vol_next;
    logic [FW-1:0]              rho_reg, rho_next;
    logic [15:0]                lo_reg, lo_next;
    logic [SW-1:0]              ins_reg, ins_next;
    logic [PW-1:0]              prod_reg, prod_next;
    logic [PW-1:0]              acc_reg, acc_next;
    logic [PW-1:0]              den_reg, den_next;
    logic [PW-1:0]              rem_reg, rem_next;
    logic [FW-1:0]              low_reg, low_next;
    logic [FW-1:0]              quo_reg, quo_next;
    logic                       sat_reg, sat_next;
    logic [CW-1:0]              m_idx_reg, m_idx_next;
    logic [FW-1:0]              m_rate_reg, m_rate_next;
    logic                       m_sat_reg, m_sat_next;

    // Input fields
    logic [ltr_pkg::ACT_W-1:0]  s_act;
    logic [CW-1:0]              s_own;
    logic [CW-1:0]              s_nbr;
    logic [FW-1:0]              s_flux;
    logic [FW-1:0]              s_vol;
    logic [FW-1:0]              s_rho;
    logic                       s_flux_pos;
    logic [FW-1:0]              s_mag;
    logic                       s_internal;
    logic                       s_boundary;
    logic [CW-1:0]              out_cell;
    logic [CW-1:0]              in_cell;
    logic                       out_cell_ok;
    logic                       in_cell_ok;
    logic                       own_cell_ok;
    logic                       accept;

    // Store ports
    logic                       wen_out, wen_in;
    logic [AW-1:0]              waddr_out, waddr_in;
    logic [SW-1:0]              wdata_out, wdata_in;
    logic [SW-1:0]              rd_out, rd_in;

    // Datapath
    logic [SW:0]                out_total, in_total;
    logic [SW-1:0]              out_new, in_new;
    logic                       gain_neg;
    logic [FW-1:0]              gmag;
    logic [FW-1:0]              mul_a, mul_b;
    logic [PW-1:0]              mul_p;
    logic [PW-1:0]              psum;
    logic [PW-1:0]              pmag;
    logic [PW-1:0]              term;
    logic [PW-1:0]              num;
    logic                       num_pos;
    logic [PW-1:0]              x_hi;
    logic [FW-1:0]              x_lo;
    logic [PW-1:0]              den;
    logic [PW:0]                shifted;
    logic [PW+1:0]              trial;
    logic                       fits;
    logic [FW-1:0]              floored;
    logic                       out_free;

    // Unpack the input item
    assign s_act  = s_tuser;
    assign s_own  = s_tdata[CW-1:0];
    assign s_nbr  = s_tdata[2*CW-1:CW];
    assign s_flux = s_tdata[2*CW+FW-1:2*CW];
    assign s_vol  = s_tdata[2*CW+2*FW-1:2*CW+FW];
    assign s_rho  = s_tdata[2*CW+3*FW-1:2*CW+2*FW];

    assign s_flux_pos = !s_flux[FW-1] && (s_flux != '0);
    assign s_mag      = s_flux[FW-1] ? (~s_flux + FW'(1)) : s_flux;
    assign s_internal = (s_act == ltr_pkg::ACT_INTERNAL);
    assign s_boundary = (s_act == ltr_pkg::ACT_BOUNDARY);

    // Pick the cells each store is read and written at
    assign out_cell    = (s_internal && !s_flux_pos) ? s_nbr : s_own;
    assign in_cell     = (s_internal && s_flux_pos) ? s_nbr : s_own;
    assign out_cell_ok = ({1'b0, out_cell} < ltr_pkg::CELL_LIMIT);
    assign in_cell_ok  = ({1'b0, in_cell} < ltr_pkg::CELL_LIMIT);
    assign own_cell_ok = ({1'b0, s_own} < ltr_pkg::CELL_LIMIT);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Saturating accumulation
    assign out_total = {1'b0, rd_out} + (SW + 1)'(mag_reg);
    assign in_total  = {1'b0, rd_in} + (SW + 1)'(mag_reg);
    assign out_new   = out_total[SW] ? ltr_pkg::SUM_MAX : out_total[SW-1:0];
    assign in_new    = in_total[SW] ? ltr_pkg::SUM_MAX : in_total[SW-1:0];

    // Gain magnitude and sign
    assign gain_neg = relax_gain_reg[FW-1];
    assign gmag     = gain_neg ? (~relax_gain_reg + FW'(1)) : relax_gain_reg;

    // Shared multiplier: gain*outflow high part, gain*outflow low part, density*volume
    always_comb
    begin
        mul_a = gmag;
        mul_b = '0;
        case (state_reg)
            ST_MUL_HI:
            begin
                mul_b = own_ok_reg ? rd_out[SW-1:16] : '0;
            end
            ST_MUL_LO:
            begin
                mul_b = FW'(lo_reg);
            end
            ST_SUM:
            begin
                mul_a = rho_reg;
                mul_b = vol_reg;
            end
            default:
            begin
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Product magnitude, clamped
    assign psum = acc_reg + {16'b0, prod_reg[PW-1:16]};
    assign pmag = (psum > ltr_pkg::CLAMP_MAG) ? ltr_pkg::CLAMP_MAG : psum;

    // Signed numerator
    assign term = gain_neg ? (~acc_reg + PW'(1)) : acc_reg;
    assign num  = PW'(ins_reg) + term;

    // Dividend halves and divisor; the numerator sits in acc_reg from here on
    assign num_pos = !acc_reg[PW-1] && (acc_reg != '0);
    assign x_hi    = mass_mode_reg ? acc_reg : {16'b0, acc_reg[PW-1:16]};
    assign x_lo    = mass_mode_reg ? '0 : {acc_reg[15:0], 16'b0};
    assign den     = mass_mode_reg ? prod_reg : PW'(vol_reg);

    // One restoring division step
    assign shifted = {rem_reg, low_reg[FW-1]};
    assign trial   = {1'b0, shifted} - (PW + 2)'(den_reg);
    assign fits    = !trial[PW+1];

    assign floored  = (quo_reg < min_rate_reg) ? min_rate_reg : quo_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Store write ports
    always_comb
    begin
        wen_out   = 1'b0;
        wen_in    = 1'b0;
        waddr_out = out_addr_reg;
        waddr_in  = in_addr_reg;
        wdata_out = out_new;
        wdata_in  = in_new;
        case (state_reg)
            ST_CLEAR:
            begin
                wen_out   = 1'b1;
                wen_in    = 1'b1;
                waddr_out = clr_reg;
                waddr_in  = clr_reg;
                wdata_out = '0;
                wdata_in  = '0;
            end
            ST_ACCUM:
            begin
                wen_out = we_out_reg;
                wen_in  = we_in_reg;
            end
            ST_DONE:
            begin
                wen_out   = out_free && own_ok_reg;
                wen_in    = out_free && own_ok_reg;
                waddr_out = own_reg[AW-1:0];
                waddr_in  = own_reg[AW-1:0];
                wdata_out = '0;
                wdata_in  = '0;
            end
            default:
            begin
                wen_out = 1'b0;
                wen_in  = 1'b0;
            end
        endcase
    end

    ltr_ram #(
        .WIDTH (SW),
        .DEPTH (ltr_pkg::STORE_DEPTH)
    ) u_outflow_ram (
        .clk   (clk),
        .wen   (wen_out),
        .waddr (waddr_out),
        .wdata (wdata_out),
        .raddr (out_cell[AW-1:0]),
        .rdata (rd_out)
    );

    ltr_ram #(
        .WIDTH (SW),
        .DEPTH (ltr_pkg::STORE_DEPTH)
    ) u_inflow_ram (
        .clk   (clk),
        .wen   (wen_in),
        .waddr (waddr_in),
        .wdata (wdata_in),
        .raddr (in_cell[AW-1:0]),
        .rdata (rd_in)
    );

    // Sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg;
        relax_gain_next = relax_gain_reg;
        min_rate_next   = min_rate_reg;
        mass_mode_next  = mass_mode_reg;
        we_out_next     = we_out_reg;
        we_in_next      = we_in_reg;
        out_addr_next   = out_addr_reg;
        in_addr_next    = in_addr_reg;
        mag_next        = mag_reg;
        own_next        = own_reg;
        own_ok_next     = own_ok_reg;
        vol_next        = vol_reg;
        rho_next        = rho_reg;
        lo_next         = lo_reg;
        ins_next        = ins_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        low_next        = low_reg;
        quo_next        = quo_reg;
        sat_next        = sat_reg;
        m_idx_next      = m_idx_reg;
        m_rate_next     = m_rate_reg;
        m_sat_next      = m_sat_reg;

        // Configuration writes
        if (cfg_wen)
        begin
            case (cfg_index)
                ltr_pkg::REG_RELAX_GAIN: relax_gain_next = cfg_wdata;
                ltr_pkg::REG_MIN_RATE:   min_rate_next   = cfg_wdata;
                ltr_pkg::REG_MASS_MODE:  mass_mode_next  = cfg_wdata[0];
                default:                 mass_mode_next  = mass_mode_reg;
            endcase
        end

        // Drop the result once it is taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    we_out_next   = (s_internal || (s_boundary && s_flux_pos)) && out_cell_ok;
                    we_in_next    = (s_internal || (s_boundary && !s_flux_pos)) && in_cell_ok;
                    out_addr_next = out_cell[AW-1:0];
                    in_addr_next  = in_cell[AW-1:0];
                    mag_next      = s_mag;
                    own_next      = s_own;
                    own_ok_next   = own_cell_ok;
                    vol_next      = s_vol;
                    rho_next      = s_rho;
                    if (s_internal || s_boundary)
                    begin
                        state_next = ST_ACCUM;
                    end
                    else if (s_act == ltr_pkg::ACT_FINISH)
                    begin
                        state_next = ST_MUL_HI;
                    end
                end
            end
            ST_ACCUM:
            begin
                state_next = ST_IDLE;
            end
            ST_MUL_HI:
            begin
                // Hold the store contents; unstored cells read as zero
                lo_next    = own_ok_reg ? rd_out[15:0] : '0;
                ins_next   = own_ok_reg ? rd_in : '0;
                prod_next  = mul_p;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                acc_next   = pmag;
                prod_next  = mul_p;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                acc_next   = num;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                den_next = den;
                rem_next = x_hi;
                low_next = x_lo;
                cnt_next = LAST_STEP;
                if (!num_pos)
                begin
                    quo_next   = '0;
                    sat_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (x_hi >= den)
                begin
                    // Quotient would not fit in 32 bits, or divisor is zero
                    quo_next   = ltr_pkg::RATE_MAX;
                    sat_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    quo_next   = '0;
                    sat_next   = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = fits ? trial[PW-1:0] : shifted[PW-1:0];
                low_next = {low_reg[FW-2:0], 1'b0};
                quo_next = {quo_reg[FW-2:0], fits};
                cnt_next = cnt_reg - ltr_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_idx_next   = own_reg;
                    m_rate_next  = floored;
                    m_sat_next   = sat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            relax_gain_reg <= ltr_pkg::RELAX_GAIN_RESET;
            min_rate_reg   <= ltr_pkg::MIN_RATE_RESET;
            mass_mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
            relax_gain_reg <= relax_gain_next;
            min_rate_reg   <= min_rate_next;
            mass_mode_reg  <= mass_mode_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        we_out_reg   <= we_out_next;
        we_in_reg    <= we_in_next;
        out_addr_reg <= out_addr_next;
        in_addr_reg  <= in_addr_next;
        mag_reg      <= mag_next;
        own_reg      <= own_next;
        own_ok_reg   <= own_ok_next;
        vol_reg      <= vol_next;
        rho_reg      <= rho_next;
        lo_reg       <= lo_next;
        ins_reg      <= ins_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        quo_reg      <= quo_next;
        sat_reg      <= sat_next;
        m_idx_reg    <= m_idx_next;
        m_rate_reg   <= m_rate_next;
        m_sat_reg    <= m_sat_next;
    end

    // Drive the result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_rate_reg, m_idx_reg};
    assign m_tuser  = m_sat_reg;

endmodule

`default_nettype wire

>>> sv/ltr_checker.sv
// Port-level checks for the local time-step rate unit, bound to the top level.
`default_nettype none

module ltr_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic [ltr_pkg::ACT_W-1:0]          s_tuser,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [ltr_pkg::OUT_DATA_W-1:0]     m_tdata,
    input wire logic [ltr_pkg::OUT_USER_W-1:0]     m_tuser
);

    localparam int RATE_LO = ltr_pkg::CELL_W;
    localparam int RATE_HI = ltr_pkg::CELL_W + ltr_pkg::FIX_W - 1;

    // Hold a stalled result
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Stores are being zeroed right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("input ready before the clearing pass");

    // Accepting a face or finish item drops s_tready
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready &&
        (s_tuser == ltr_pkg::ACT_INTERNAL || s_tuser == ltr_pkg::ACT_BOUNDARY ||
         s_tuser == ltr_pkg::ACT_FINISH)
        |=> !s_tready)
        else $error("input ready straight after a face or finish item");

    // A face item never produces a result
    a_face_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid &&
        (s_tuser == ltr_pkg::ACT_INTERNAL || s_tuser == ltr_pkg::ACT_BOUNDARY)
        |=> !m_tvalid)
        else $error("result appeared after a face item");

    // A clipped result carries the largest rate
    a_sat_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[RATE_HI:RATE_LO] == ltr_pkg::RATE_MAX)
        else $error("saturated result without the maximum rate");

endmodule

bind local_timestep_rate_unit ltr_checker u_ltr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
